// ===== rtl/ils_pkg.sv =====
// shared types, constants and codes for the indexed list store
`timescale 1ns / 1ps
package ils_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int CMD_W        = 3;
  localparam int POS_W        = 10;
  localparam int VAL_W        = 32;
  localparam int ECNT_W       = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ = 3'd0,
    CMD_HEAD = 3'd1,
    CMD_TAIL = 3'd2,
    CMD_AT   = 3'd3,
    CMD_DEL  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_ONES,
    SRC_RAM
  } res_src_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ_WAIT,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } in_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    status_t                 status;
    logic [ECNT_W-1:0]       element_count;
  } out_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic     capture;
    logic     rd_at_pos;
    logic     up_start;
    logic     dn_start;
    logic     shift_up;
    logic     shift_dn;
    logic     place;
    logic     shrink;
    logic     res_load;
    res_src_t res_src;
    status_t  res_status;
    logic     out_load;
  } ils_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             pos_lt_cnt;
    logic             pos_le_cnt;
    logic             full;
    logic             up_done;
    logic             dn_done;
    logic             out_free;
  } ils_sts_t;

endpackage

// ===== rtl/indexed_list_store_unit.sv =====
// top level of the indexed list store
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY signed 32-bit values kept in one ram in
// positional order. Each request on the in_ channel (valid/ready) carries a
// command, a position and a value; each request yields exactly one response
// on the out_ channel with the read value, a status and the new element count.
// Requests are handled one at a time: in_ready is high only while the
// sequencer is idle and out of reset.
// Steps from accept to out_valid, with n the count before the command:
//   read: decode, ram read, finish; rejected or unknown command: decode, finish
//   insert at position p (head p = 0, tail p = n): decode, shift n - p entries up, place
//   delete at position p: decode, shift n - p - 1 entries down, shrink
// The element shift moves one entry per cycle through the single write port
// of the ram, so a head insert on a nearly full list or a head delete on a
// full list moves nearly CAPACITY entries. in_ready returns at the same edge
// that raises out_valid.
// The response sits in an output register; a stalled receiver holds it while
// the next request is accepted and processed, and only the final handoff of
// that next response waits for out_ready.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// response; the ram contents are not cleared and need no sweep.
module indexed_list_store_unit #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ils_pkg::in_req_t in_req,
  output logic             out_valid,
  input  logic             out_ready,
  output ils_pkg::out_rsp_t out_rsp
);
  import ils_pkg::*;

  ils_ctl_t ctl;
  ils_sts_t sts;

  ils_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .ctl     (ctl)
  );

  ils_dpath #(
    .CAPACITY(CAPACITY)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .ctl      (ctl),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rsp  (out_rsp)
  );

endmodule

// ===== rtl/ils_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ils_ctrl.sv =====
// controller state machine for the indexed list store
`timescale 1ns / 1ps
module ils_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ils_pkg::ils_sts_t sts,
  output ils_pkg::ils_ctl_t ctl
);
  import ils_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.command)
          CMD_READ: state_nxt = sts.pos_lt_cnt ? S_READ_WAIT : S_FINISH;
          CMD_HEAD, CMD_TAIL: state_nxt = sts.full ? S_FINISH : S_SHIFT_UP;
          CMD_AT: begin
            if (!sts.pos_le_cnt || sts.full) state_nxt = S_FINISH;
            else state_nxt = S_SHIFT_UP;
          end
          CMD_DEL: state_nxt = sts.pos_lt_cnt ? S_SHIFT_DN : S_FINISH;
          default: state_nxt = S_FINISH;
        endcase
      end
      S_READ_WAIT: state_nxt = S_FINISH;
      S_SHIFT_UP: begin
        if (sts.up_done) state_nxt = S_FINISH;
      end
      S_SHIFT_DN: begin
        if (sts.dn_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl            = '0;
    ctl.res_src    = SRC_ZERO;
    ctl.res_status = ST_DONE;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // no request is taken while reset is held
        in_ready    = rst_n;
        ctl.capture = in_valid;
      end
      S_DECODE: begin
        ctl.res_load = 1'b1;
        unique case (sts.command)
          CMD_READ: begin
            if (sts.pos_lt_cnt) begin
              ctl.rd_at_pos = 1'b1;
              ctl.res_load  = 1'b0;
            end else begin
              ctl.res_src    = SRC_ONES;
              ctl.res_status = ST_RANGE;
            end
          end
          CMD_HEAD, CMD_TAIL, CMD_AT: begin
            // range check wins over the full check
            if (sts.command == CMD_AT && !sts.pos_le_cnt) begin
              ctl.res_status = ST_RANGE;
            end else if (sts.full) begin
              ctl.res_status = ST_FULL;
            end else begin
              ctl.up_start = 1'b1;
            end
          end
          CMD_DEL: begin
            if (sts.pos_lt_cnt) ctl.dn_start = 1'b1;
            else ctl.res_status = ST_RANGE;
          end
          default: ;
        endcase
      end
      S_READ_WAIT: begin
        ctl.res_load = 1'b1;
        ctl.res_src  = SRC_RAM;
      end
      S_SHIFT_UP: begin
        ctl.shift_up = 1'b1;
        ctl.place    = sts.up_done;
      end
      S_SHIFT_DN: begin
        ctl.shift_dn = 1'b1;
        ctl.shrink   = sts.dn_done;
      end
      S_FINISH: begin
        ctl.out_load = sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/ils_dpath.sv =====
// datapath of the indexed list store: element ram, count, shift pointers, result register
`timescale 1ns / 1ps
module ils_dpath #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ils_pkg::in_req_t  in_req,
  input  ils_pkg::ils_ctl_t ctl,
  output ils_pkg::ils_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output ils_pkg::out_rsp_t out_rsp
);
  import ils_pkg::*;

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int AW  = $clog2(CAPACITY);
  localparam int PCW = (CW > POS_W) ? CW : POS_W;

  in_req_t            req_r, req_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      ptr_r, ptr_nxt;
  logic [CW-1:0]      ins_r, ins_nxt;
  logic [AW-1:0]      dst_r, dst_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic [VAL_W-1:0]   res_value_r, res_value_nxt;
  status_t            res_status_r, res_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_rsp_t           out_rsp_r, out_rsp_nxt;

  logic [PCW-1:0]     pos_ext;
  logic [PCW-1:0]     cnt_ext;
  logic [CW-1:0]      ptr_dec;
  logic [CW-1:0]      ptr_inc;
  logic               up_more;
  logic               dn_more;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [VAL_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [VAL_W-1:0]   ram_rdata;

  assign pos_ext = PCW'(req_r.position);
  assign cnt_ext = PCW'(count_r);
  assign ptr_dec = ptr_r - 1'b1;
  assign ptr_inc = ptr_r + 1'b1;
  assign up_more = ptr_r > ins_r;
  assign dn_more = ptr_inc < count_r;

  always_comb begin
    sts.command    = req_r.command;
    sts.pos_lt_cnt = pos_ext < cnt_ext;
    sts.pos_le_cnt = pos_ext <= cnt_ext;
    sts.full       = count_r == CW'(CAPACITY);
    sts.up_done    = !up_more && !rd_pend_r;
    sts.dn_done    = !dn_more && !rd_pend_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // ram ports: each read lands in the next cycle and is written one slot over
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = AW'(req_r.position);
    ram_we    = 1'b0;
    ram_waddr = dst_r;
    ram_wdata = ram_rdata;
    if (ctl.rd_at_pos) begin
      ram_re = 1'b1;
    end else if (ctl.shift_up && up_more) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(ptr_dec);
    end else if (ctl.shift_dn && dn_more) begin
      ram_re    = 1'b1;
      ram_raddr = AW'(ptr_inc);
    end
    if ((ctl.shift_up || ctl.shift_dn) && rd_pend_r) begin
      ram_we = 1'b1;
    end else if (ctl.place) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(ins_r);
      ram_wdata = req_r.item_value;
    end
  end

  always_comb begin
    req_nxt        = ctl.capture ? in_req : req_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    ins_nxt        = ins_r;
    dst_nxt        = dst_r;
    rd_pend_nxt    = 1'b0;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_rsp_nxt    = out_rsp_r;

    if (ctl.up_start) begin
      ptr_nxt = count_r;
      unique case (req_r.command)
        CMD_HEAD: ins_nxt = '0;
        CMD_TAIL: ins_nxt = count_r;
        default:  ins_nxt = CW'(pos_ext);
      endcase
    end
    if (ctl.dn_start) begin
      ptr_nxt = CW'(pos_ext);
    end
    if (ctl.shift_up && up_more) begin
      ptr_nxt     = ptr_dec;
      dst_nxt     = AW'(ptr_r);
      rd_pend_nxt = 1'b1;
    end
    if (ctl.shift_dn && dn_more) begin
      ptr_nxt     = ptr_inc;
      dst_nxt     = AW'(ptr_r);
      rd_pend_nxt = 1'b1;
    end
    if (ctl.place) count_nxt = count_r + 1'b1;
    if (ctl.shrink) count_nxt = count_r - 1'b1;

    if (ctl.res_load) begin
      res_status_nxt = ctl.res_status;
      unique case (ctl.res_src)
        SRC_ONES: res_value_nxt = '1;
        SRC_RAM:  res_value_nxt = ram_rdata;
        default:  res_value_nxt = '0;
      endcase
    end

    if (ctl.out_load) begin
      out_valid_nxt             = 1'b1;
      out_rsp_nxt.read_value    = res_value_r;
      out_rsp_nxt.status        = res_status_r;
      out_rsp_nxt.element_count = ECNT_W'(count_r);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    ptr_r        <= ptr_nxt;
    ins_r        <= ins_nxt;
    dst_r        <= dst_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_rsp_r    <= out_rsp_nxt;
  end

  ils_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ===== rtl/ils_checker.sv =====
// port level checks for the indexed list store, bound to the top level
`timescale 1ns / 1ps
module ils_checker #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ils_pkg::out_rsp_t out_rsp
);
  import ils_pkg::*;

  // a held response keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("response changed while stalled");

  // one request in flight: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // full rejection only when the list is at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status == ST_FULL |->
      out_rsp.element_count == ECNT_W'(CAPACITY))
    else $error("full status with list not at capacity");

  // out of range answers carry -1 for reads and zero otherwise
  a_range_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status == ST_RANGE |->
      out_rsp.read_value == -32'sd1 || out_rsp.read_value == 32'sd0)
    else $error("bad value with range status");

  // count never goes past capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> CAPACITY >= (1 << ECNT_W) ||
      int'(out_rsp.element_count) <= CAPACITY)
    else $error("element count above capacity");

endmodule

bind indexed_list_store_unit ils_checker #(
  .CAPACITY(CAPACITY)
) u_ils_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_rsp  (out_rsp)
);
